[rtl/assert_macros.svh]
// Assertion macros used by bezout_coefficients.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

[rtl/bezc_pkg.sv]
`timescale 1ns / 1ps
package bezc_pkg;
  localparam int unsigned WIDTH_DEF = 32;
  localparam int unsigned MAX_STEPS_DEF = 48;
  localparam int unsigned OUT_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BACK_RD,
    ST_BACK_MUL,
    ST_BACK_ADD,
    ST_OUT
  } bezc_state_t;
endpackage

[rtl/bezout_coefficients.sv]
`timescale 1ns / 1ps
// Channel  Dir  tdata fields (low bit up)
// in_      in   first_operand[31:0], second_operand[63:32]
// out_     out  gcd_value, coef_larger, coef_smaller, larger_positive, zero_error; 0 pad to 104
// One word at a time. Each division is bit serial, and the chain runs up to MAX_STEPS + 1
// divisions; the back recurrence then steps through memory read, multiply and add for each
// stored quotient, plus one final read state.
// Reset is synchronous, active low, and clears control only; the quotient memory
// needs no clearing. in_tready is low while a word is at work or its result waits.
`include "assert_macros.svh"
module bezout_coefficients #(
  parameter int unsigned WIDTH = bezc_pkg::WIDTH_DEF,
  parameter int unsigned MAX_STEPS = bezc_pkg::MAX_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // first_operand, second_operand
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // gcd_value, coef_larger, coef_smaller,
                                   // larger_positive, zero_error, zero pad
);
  import bezc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_STEPS);
  localparam int unsigned CW = $clog2(MAX_STEPS + 1);
  localparam int unsigned BW = $clog2(WIDTH + 1);

  bezc_state_t state_r, state_nxt;

  logic [WIDTH-1:0] dvd_r, dvd_nxt;    // running dividend, shifted into quotient
  logic [WIDTH-1:0] dvs_r, dvs_nxt;    // running divisor
  logic [WIDTH:0]   rem_r, rem_nxt;
  logic [BW-1:0]    bit_r, bit_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;    // quotients stored
  logic [CW-1:0]    idx_r, idx_nxt;    // back recurrence index
  logic [WIDTH-1:0] cp_r, cp_nxt, cc_r, cc_nxt, prod_r, prod_nxt;
  logic             err_r, err_nxt;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [WIDTH-1:0] rdata;
  logic [WIDTH-1:0] quot_fin;

  bezc_ram #(.DATA_W(WIDTH), .DEPTH(MAX_STEPS)) u_qram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(quot_fin), .raddr(raddr), .rdata(rdata)
  );

  logic [WIDTH-1:0] a_in, b_in;
  logic [WIDTH:0]   rem_sh, rem_sub, rem_fin;
  logic             q_bit;

  always_comb begin
    a_in = WIDTH'(in_tdata[31:0]);
    b_in = WIDTH'(in_tdata[63:32]);
    rem_sh = {rem_r[WIDTH-1:0], dvd_r[WIDTH-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    q_bit = !rem_sub[WIDTH];
    rem_fin = q_bit ? rem_sub : rem_sh;
    quot_fin = {dvd_r[WIDTH-2:0], q_bit};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (a_in == '0 || b_in == '0) state_nxt = ST_OUT;
          else state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (bit_r == BW'(WIDTH - 1)) begin
          if (rem_fin == '0) begin
            state_nxt = (cnt_r == '0) ? ST_OUT : ST_BACK_RD;
          end else if (cnt_r >= CW'(MAX_STEPS)) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_BACK_RD: state_nxt = (idx_r == '0) ? ST_OUT : ST_BACK_MUL;
      ST_BACK_MUL: state_nxt = ST_BACK_ADD;
      ST_BACK_ADD: state_nxt = ST_BACK_RD;
      ST_OUT: if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    rem_nxt = rem_r;
    bit_nxt = bit_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    cp_nxt = cp_r;
    cc_nxt = cc_r;
    prod_nxt = prod_r;
    err_nxt = err_r;
    we = 1'b0;
    waddr = cnt_r[AW-1:0];
    raddr = AW'(idx_r - CW'(1));
    in_tready = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    case (state_r)
      ST_IDLE: begin
        bit_nxt = '0;
        rem_nxt = '0;
        cnt_nxt = '0;
        idx_nxt = '0;
        err_nxt = (a_in == '0 || b_in == '0);
        dvd_nxt = (b_in > a_in) ? b_in : a_in;
        dvs_nxt = (b_in > a_in) ? a_in : b_in;
        cp_nxt = '0;
        cc_nxt = WIDTH'(1);
      end
      ST_DIV: begin
        rem_nxt = rem_fin;
        dvd_nxt = quot_fin;
        bit_nxt = bit_r + BW'(1);
        if (bit_r == BW'(WIDTH - 1)) begin
          bit_nxt = '0;
          if (rem_fin != '0) begin
            if (cnt_r >= CW'(MAX_STEPS)) begin
              err_nxt = 1'b1;
            end else begin
              // Quotient is complete this cycle; store it and shift operands.
              we = 1'b1;
              waddr = cnt_r[AW-1:0];
              cnt_nxt = cnt_r + CW'(1);
              dvd_nxt = dvs_r;
              dvs_nxt = rem_fin[WIDTH-1:0];
              rem_nxt = '0;
              idx_nxt = cnt_r + CW'(1);
              cp_nxt = '0;
              cc_nxt = WIDTH'(1);
            end
          end
        end
      end
      ST_BACK_RD: begin
        // Memory read of quotient idx-1 lands next cycle.
        raddr = AW'(idx_r - CW'(1));
      end
      ST_BACK_MUL: begin
        prod_nxt = WIDTH'(cc_r * rdata);
      end
      ST_BACK_ADD: begin
        cp_nxt = cc_r;
        cc_nxt = prod_r + cp_r;
        idx_nxt = idx_r - CW'(1);
      end
      default: ;
    endcase
  end

  logic [OUT_W-1:0] gcd_o, s_o, t_o;
  always_comb begin
    gcd_o = err_r ? '0 : OUT_W'(dvs_r);
    s_o = err_r ? '0 : OUT_W'(cp_r);
    t_o = err_r ? '0 : OUT_W'(cc_r);
    out_tdata = {6'b0, err_r, (!err_r && cnt_r[0]), t_o, s_o, gcd_o};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      idx_r <= '0;
      bit_r <= '0;
      err_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      bit_r <= bit_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    cp_r <= cp_nxt;
    cc_r <= cc_nxt;
    prod_r <= prod_nxt;
  end

  `ASSERT_NEVER(a_ready_busy, clk, rst_n, in_tready && out_tvalid, "ready while result held")
  `ASSERT_CLK(a_cnt_range, clk, rst_n, cnt_r <= CW'(MAX_STEPS), "quotient count overflow")
  `ASSERT_CLK(a_idx_le_cnt, clk, rst_n, idx_r <= cnt_r || state_r == ST_IDLE, "bad back index")
  `ASSERT_NEVER(a_err_flag, clk, rst_n, out_tvalid && err_r && out_tdata[96], "flag on error")
endmodule

[rtl/bezc_ram.sv]
`timescale 1ns / 1ps
module bezc_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[dv/bezout_coefficients_tb.sv]
`timescale 1ns / 1ps
module bezout_coefficients_tb;
  import bezc_pkg::*;

  typedef struct packed {
    logic        zero_error;
    logic        larger_positive;
    logic [31:0] coef_smaller;
    logic [31:0] coef_larger;
    logic [31:0] gcd_value;
  } bezout_res_t;

  typedef struct {
    logic [31:0] first_op;
    logic [31:0] second_op;
    bit          has_typed;
    bezout_res_t typed;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;

  bezout_res_t expected_results[$];
  int          mismatch_count;
  bit          stim_done;
  bit          calm_phase;

  bezout_coefficients uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Extended Euclid: keep the quotients of the chain, then run the recurrence backward.
  function automatic bezout_res_t bezout_predict(logic [31:0] x, logic [31:0] y);
    bezout_res_t r;
    logic [31:0] quots[48];
    logic [31:0] dividend, divisor, rem, big, sml, s_prev, s_curr, nxt;
    int          nq;
    r = '0;
    if (x == 0 || y == 0) begin
      r.zero_error = 1'b1;
      return r;
    end
    big = (y > x) ? y : x;
    sml = (y > x) ? x : y;
    dividend = big;
    divisor = sml;
    nq = 0;
    forever begin
      rem = dividend % divisor;
      if (rem == 0) break;
      quots[nq] = dividend / divisor;
      nq++;
      dividend = divisor;
      divisor = rem;
    end
    if (nq == 0) begin
      s_prev = 0;
      s_curr = 1;
    end else begin
      s_prev = 1;
      s_curr = quots[nq-1];
      for (int i = nq - 1; i > 0; i--) begin
        nxt = s_prev + s_curr * quots[i-1];
        s_prev = s_curr;
        s_curr = nxt;
      end
    end
    r.gcd_value = divisor;
    r.coef_larger = s_prev;
    r.coef_smaller = s_curr;
    r.larger_positive = nq[0];
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic [31:0] a, logic [31:0] b, bit typed = 0,
                                       bezout_res_t res = '0);
    stim_row_t row;
    row.first_op = a;
    row.second_op = b;
    row.has_typed = typed;
    row.typed = res;
    return row;
  endfunction

  function automatic bezout_res_t err_res();
    bezout_res_t r;
    r = '0;
    r.zero_error = 1'b1;
    return r;
  endfunction

  function automatic bezout_res_t div_res(logic [31:0] g);
    bezout_res_t r;
    r = '0;
    r.gcd_value = g;
    r.coef_smaller = 32'd1;
    return r;
  endfunction

  // Leaves in_tvalid high after the accepting edge; the caller drops it after the last word.
  task automatic send_word(logic [31:0] a, logic [31:0] b, bezout_res_t exp_res);
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b, a};
    expected_results.push_back(exp_res);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Operand with a random bit length so chains of every depth show up.
  function automatic logic [31:0] rand_operand();
    int nbits;
    nbits = $urandom_range(1, 32);
    return $urandom() >> (32 - nbits);
  endfunction

  initial begin
    stim_row_t   rows[$];
    logic [31:0] a, b, g, fa, fb;
    int          kind;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatch_count = 0;
    stim_done = 0;
    calm_phase = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back(mk_row(32'd0, 32'd0, 1, err_res()));
    rows.push_back(mk_row(32'd0, 32'd5, 1, err_res()));
    rows.push_back(mk_row(32'hFFFF_FFFF, 32'd0, 1, err_res()));
    rows.push_back(mk_row(32'd1, 32'd1, 1, div_res(32'd1)));
    rows.push_back(mk_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, div_res(32'hFFFF_FFFF)));
    rows.push_back(mk_row(32'hFFFF_FFFF, 32'd1, 1, div_res(32'd1)));
    rows.push_back(mk_row(32'd1, 32'hFFFF_FFFF, 1, div_res(32'd1)));
    rows.push_back(mk_row(32'd12, 32'd48, 1, div_res(32'd12)));
    rows.push_back(mk_row(32'd240, 32'd46));
    rows.push_back(mk_row(32'd46, 32'd240));
    rows.push_back(mk_row(32'hFFFF_FFFF, 32'hFFFF_FFFE));
    rows.push_back(mk_row(32'hFFFF_FFFE, 32'h8000_0000));
    rows.push_back(mk_row(32'h5555_5555, 32'hAAAA_AAAA));
    rows.push_back(mk_row(32'd2971215073, 32'd1836311903)); // longest Fibonacci chain
    rows.push_back(mk_row(32'd1836311903, 32'd1134903170));
    rows.push_back(mk_row(32'd3, 32'd2));
    rows.push_back(mk_row(32'h8000_0001, 32'h7FFF_FFFF));
    foreach (rows[i])
      send_word(rows[i].first_op, rows[i].second_op,
                rows[i].has_typed ? rows[i].typed
                                  : bezout_predict(rows[i].first_op, rows[i].second_op));

    for (int n = 0; n < 370; n++) begin
      if (n >= 330) calm_phase = 1;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        a = ($urandom_range(0, 1)) ? 32'd0 : $urandom();
        b = (a != 0 || $urandom_range(0, 1)) ? 32'd0 : $urandom();
      end else if (kind <= 2) begin
        // One operand a multiple of the other.
        a = rand_operand();
        if (a == 0) a = 1;
        b = a * $urandom_range(1, 40);
      end else if (kind <= 4) begin
        // Consecutive Fibonacci numbers give the longest chains.
        fa = 1;
        fb = 1;
        repeat ($urandom_range(2, 45)) begin
          g = fa + fb;
          fa = fb;
          fb = g;
        end
        a = fb;
        b = fa;
      end else if (kind <= 7) begin
        g = $urandom_range(2, 1000);
        a = ($urandom() >> $urandom_range(10, 31)) * g + g;
        b = ($urandom() >> $urandom_range(10, 31)) * g + g;
      end else begin
        a = ($urandom_range(0, 3) == 0) ? $urandom() : rand_operand();
        b = ($urandom_range(0, 3) == 0) ? $urandom() : rand_operand();
      end
      if ($urandom_range(0, 1)) begin
        g = a;
        a = b;
        b = g;
      end
      send_word(a, b, bezout_predict(a, b));
    end
    in_tvalid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    bezout_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = bezout_res_t'(out_tdata[97:0]);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word: actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.gcd_value !== want.gcd_value) begin
          $display("%0t: gcd_value expected %h actual %h", $time, want.gcd_value,
                   got.gcd_value);
          mismatch_count++;
        end
        if (got.coef_larger !== want.coef_larger) begin
          $display("%0t: coef_larger expected %h actual %h", $time, want.coef_larger,
                   got.coef_larger);
          mismatch_count++;
        end
        if (got.coef_smaller !== want.coef_smaller) begin
          $display("%0t: coef_smaller expected %h actual %h", $time, want.coef_smaller,
                   got.coef_smaller);
          mismatch_count++;
        end
        if (got.larger_positive !== want.larger_positive) begin
          $display("%0t: larger_positive expected %b actual %b", $time,
                   want.larger_positive, got.larger_positive);
          mismatch_count++;
        end
        if (got.zero_error !== want.zero_error) begin
          $display("%0t: zero_error expected %b actual %b", $time, want.zero_error,
                   got.zero_error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[bezout_coefficients] OK");
    end else begin
      $display("[bezout_coefficients] ERROR");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("[bezout_coefficients] ERROR");
    $finish;
  end
endmodule

[bezout_coefficients.f]
+incdir+rtl
rtl/bezc_pkg.sv
rtl/bezc_ram.sv
rtl/bezout_coefficients.sv
dv/bezout_coefficients_tb.sv
